>>> rtl/dqe_pkg.sv
`default_nettype none

package dqe_pkg;

    // Storage geometry
    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Field widths of one request and one result
    localparam int MODE_W = 3;
    localparam int VAL_W  = 32;
    localparam int OFF_W  = 6;
    localparam int RD_W   = 32;
    localparam int ST_W   = 2;
    localparam int OCC_W  = 7;

    localparam int IN_BITS     = MODE_W + VAL_W + OFF_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = RD_W + ST_W + OCC_W + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

    // Request codes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK       = 3'd4;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_OVER  = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDER = 2'd2;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic              shift_back;   // push at front: every cell takes its front neighbor
        logic              shift_front;  // pop at front: every cell takes its back neighbor
        logic              tap_load;     // copy data into the tap line
        logic              tap_shift;    // move the tap line one cell toward the front
        logic [DATA_W-1:0] data;         // value entering at the front or at the back
    } t_cell_ctl;

    typedef struct packed {
        logic [RD_W-1:0]  read_value;
        logic [ST_W-1:0]  status;
        logic [OCC_W-1:0] occupancy;
        logic             is_empty;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/dqe_cell.sv
`default_nettype none

// One element slot plus one tap stage of the read-out line.
module dqe_cell (
    input  wire                     i_clk,
    input  wire dqe_pkg::t_cell_ctl i_ctl,
    input  wire                     i_wr,
    input  wire [dqe_pkg::DATA_W-1:0] i_prev_data,
    input  wire [dqe_pkg::DATA_W-1:0] i_next_data,
    input  wire [dqe_pkg::DATA_W-1:0] i_next_tap,
    output logic [dqe_pkg::DATA_W-1:0] o_data,
    output logic [dqe_pkg::DATA_W-1:0] o_tap
);

    logic [dqe_pkg::DATA_W-1:0] r_data;
    logic [dqe_pkg::DATA_W-1:0] r_tap;
    logic [dqe_pkg::DATA_W-1:0] n_data;
    logic [dqe_pkg::DATA_W-1:0] n_tap;

    always_comb begin
        n_data = r_data;
        if (i_ctl.shift_back) begin
            n_data = i_prev_data;
        end else if (i_ctl.shift_front) begin
            n_data = i_next_data;
        end else if (i_wr) begin
            n_data = i_ctl.data;
        end

        n_tap = r_tap;
        if (i_ctl.tap_load) begin
            n_tap = r_data;
        end else if (i_ctl.tap_shift) begin
            n_tap = i_next_tap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_tap  <= n_tap;
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;

endmodule

`default_nettype wire

>>> rtl/dqe_ctrl.sv
`default_nettype none

// Request decode, element count, read-out walk and the two-deep result queue.
module dqe_ctrl (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire [dqe_pkg::MODE_W-1:0]  i_mode,
    input  wire [dqe_pkg::VAL_W-1:0]   i_push_value,
    input  wire [dqe_pkg::OFF_W-1:0]   i_offset,
    input  wire [dqe_pkg::DATA_W-1:0]  i_front_data,
    input  wire [dqe_pkg::DATA_W-1:0]  i_tap0,
    output dqe_pkg::t_cell_ctl         o_ctl,
    output logic                       o_wr_back,
    output logic [dqe_pkg::CNT_W-1:0]  o_count,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output dqe_pkg::t_result           o_result
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state                      r_state, n_state;
    logic [dqe_pkg::CNT_W-1:0]   r_count, n_count;
    logic [dqe_pkg::ADDR_W-1:0]  r_walk,  n_walk;
    dqe_pkg::t_result            r_hold,  n_hold;
    logic                        r_pend_v, n_pend_v;
    dqe_pkg::t_result            r_pend,  n_pend;
    logic                        r_out_v, n_out_v;
    dqe_pkg::t_result            r_out,   n_out;

    logic                        accept;
    logic                        out_free;
    logic                        full;
    logic                        empty;
    logic                        go_walk;
    logic                        res_done;
    dqe_pkg::t_result            res;
    dqe_pkg::t_cell_ctl          ctl;
    logic                        wr_back;

    assign out_free   = !r_out_v || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && (!r_pend_v || out_free);
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == dqe_pkg::CNT_W'(dqe_pkg::DEPTH));
    assign empty      = (r_count == '0);

    always_comb begin
        ctl            = '0;
        ctl.data       = dqe_pkg::DATA_W'(i_push_value);
        wr_back        = 1'b0;
        go_walk        = 1'b0;
        n_count        = r_count;
        n_walk         = r_walk;
        n_state        = r_state;
        res.read_value = '0;
        res.status     = dqe_pkg::ST_OK;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        dqe_pkg::MODE_PUSH_FRONT: begin
                            if (full) begin
                                res.status = dqe_pkg::ST_OVER;
                            end else begin
                                ctl.shift_back = 1'b1;
                                n_count        = r_count + 1'b1;
                            end
                        end
                        dqe_pkg::MODE_PUSH_BACK: begin
                            if (full) begin
                                res.status = dqe_pkg::ST_OVER;
                            end else begin
                                wr_back = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        dqe_pkg::MODE_POP_FRONT: begin
                            if (empty) begin
                                res.status = dqe_pkg::ST_UNDER;
                            end else begin
                                res.read_value  = dqe_pkg::RD_W'(i_front_data);
                                ctl.shift_front = 1'b1;
                                n_count         = r_count - 1'b1;
                            end
                        end
                        dqe_pkg::MODE_POP_BACK: begin
                            if (empty) begin
                                res.status = dqe_pkg::ST_UNDER;
                            end else begin
                                ctl.tap_load = 1'b1;
                                go_walk      = 1'b1;
                                n_count      = r_count - 1'b1;
                                n_walk       = dqe_pkg::ADDR_W'(r_count - 1'b1);
                            end
                        end
                        dqe_pkg::MODE_PEEK: begin
                            if (32'(i_offset) >= 32'(r_count)) begin
                                res.status = dqe_pkg::ST_UNDER;
                            end else begin
                                ctl.tap_load = 1'b1;
                                go_walk      = 1'b1;
                                n_walk       = dqe_pkg::ADDR_W'(i_offset);
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (go_walk) begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (r_walk == '0) begin
                    n_state = S_IDLE;
                end else begin
                    ctl.tap_shift = 1'b1;
                    n_walk        = r_walk - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        res.occupancy = dqe_pkg::OCC_W'(n_count);
        res.is_empty  = (n_count == '0);

        // Walk results carry the status and count latched at acceptance
        n_hold = r_hold;
        if (accept && go_walk) begin
            n_hold = res;
        end
        res_done = (accept && !go_walk) || ((r_state == S_WALK) && (r_walk == '0));
        if (r_state == S_WALK) begin
            res            = r_hold;
            res.read_value = dqe_pkg::RD_W'(i_tap0);
        end

        // Result queue: pending slot feeds the output register
        n_out_v  = r_out_v;
        n_out    = r_out;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        if (out_free) begin
            n_out_v  = r_pend_v;
            n_out    = r_pend;
            n_pend_v = 1'b0;
        end
        if (res_done) begin
            n_pend_v = 1'b1;
            n_pend   = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_walk   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_walk   <= n_walk;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_ctl       = ctl;
    assign o_wr_back   = wr_back;
    assign o_count     = r_count;
    assign o_out_valid = r_out_v;
    assign o_result    = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dqe_pkg::CNT_W'(dqe_pkg::DEPTH))
        else $error("element count beyond depth");

    a_no_pend_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_done |-> (!r_pend_v || out_free))
        else $error("result written over a waiting result");

    a_walk_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> !o_in_ready)
        else $error("request taken during read-out walk");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !full && (i_mode == dqe_pkg::MODE_PUSH_FRONT
                             || i_mode == dqe_pkg::MODE_PUSH_BACK))
        |=> (r_count == $past(r_count) + dqe_pkg::CNT_W'(1)))
        else $error("push did not raise the count");

endmodule

`default_nettype wire

>>> rtl/double_ended_queue.sv
`default_nettype none

// Bounded double-ended queue of dqe_pkg::DEPTH elements built as a chain of cells.
// Cell 0 always holds the front element; the back element sits in cell count-1.
// Input channel s_*: one request per beat (push front, push back, pop front,
// pop back, peek at offset). Output channel m_*: one result beat per request,
// in request order, carrying the element read, a status, the occupancy after
// the request and an empty flag.
// Timing: push front, push back, pop front, every refused request and unused
// codes finish in the accept cycle; the result goes through the pending slot
// and the output register to m_tvalid, and a new request may follow at once.
// Pop back and peek read through the tap line of the chain, which moves one
// cell toward the front per cycle: such a request walks the tap line k cells,
// with k = count - 1 for pop back and k = offset for peek; s_tready stays low
// during that walk.
// Results pass through a pending slot and an output register, so one more
// request is taken while a result waits on a stalled receiver; after that
// s_tready drops until m_tready frees the output.
// Reset clears the count, the walk and both result slots; element cells
// are not cleared and are only read once written by a push.
module double_ended_queue (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // mode[2:0], push_value[34:3], offset[40:35], zero pad up to 47
    input  wire [dqe_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // read_value[31:0], status[33:32], occupancy[40:34], is_empty[41], zero pad up to 47
    output logic [dqe_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int VAL_LO = dqe_pkg::MODE_W;
    localparam int OFF_LO = dqe_pkg::MODE_W + dqe_pkg::VAL_W;

    logic [dqe_pkg::MODE_W-1:0]  in_mode;
    logic [dqe_pkg::VAL_W-1:0]   in_value;
    logic [dqe_pkg::OFF_W-1:0]   in_offset;

    dqe_pkg::t_cell_ctl          cell_ctl;
    logic                        wr_back;
    logic [dqe_pkg::CNT_W-1:0]   count;
    dqe_pkg::t_result            result;

    logic [dqe_pkg::DATA_W-1:0]  cell_data [dqe_pkg::DEPTH];
    logic [dqe_pkg::DATA_W-1:0]  cell_tap  [dqe_pkg::DEPTH];

    // Unpack the request beat
    assign in_mode   = s_tdata[dqe_pkg::MODE_W-1:0];
    assign in_value  = s_tdata[VAL_LO +: dqe_pkg::VAL_W];
    assign in_offset = s_tdata[OFF_LO +: dqe_pkg::OFF_W];

    dqe_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_tvalid),
        .o_in_ready   (s_tready),
        .i_mode       (in_mode),
        .i_push_value (in_value),
        .i_offset     (in_offset),
        .i_front_data (cell_data[0]),
        .i_tap0       (cell_tap[0]),
        .o_ctl        (cell_ctl),
        .o_wr_back    (wr_back),
        .o_count      (count),
        .o_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .o_result     (result)
    );

    // Chain of cells: data shifts both ways, taps drain toward the front
    for (genvar i = 0; i < dqe_pkg::DEPTH; i++) begin : g_cell
        logic [dqe_pkg::DATA_W-1:0] prev_data;
        logic [dqe_pkg::DATA_W-1:0] next_data;
        logic [dqe_pkg::DATA_W-1:0] next_tap;
        logic                       wr_here;

        if (i == 0) begin : g_head
            assign prev_data = cell_ctl.data;
        end else begin : g_body
            assign prev_data = cell_data[i-1];
        end

        if (i == dqe_pkg::DEPTH - 1) begin : g_tail
            assign next_data = '0;
            assign next_tap  = '0;
        end else begin : g_mid
            assign next_data = cell_data[i+1];
            assign next_tap  = cell_tap[i+1];
        end

        // Push back lands in the first free cell
        assign wr_here = wr_back &&
                         (count[dqe_pkg::ADDR_W-1:0] == dqe_pkg::ADDR_W'(i));

        dqe_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl),
            .i_wr        (wr_here),
            .i_prev_data (prev_data),
            .i_next_data (next_data),
            .i_next_tap  (next_tap),
            .o_data      (cell_data[i]),
            .o_tap       (cell_tap[i])
        );
    end

    // Pack the result beat
    assign m_tdata = {{dqe_pkg::OUT_PAD_W{1'b0}}, result.is_empty, result.occupancy,
                      result.status, result.read_value};

endmodule

`default_nettype wire
